@@ src/mandelbox_distance_estimate_macros.svh @@
// assertion macros shared by the mandelbox distance estimate modules
`ifndef MANDELBOX_DISTANCE_ESTIMATE_MACROS_SVH
`define MANDELBOX_DISTANCE_ESTIMATE_MACROS_SVH

// same-cycle implication
`define MDE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mde same-cycle check failed");

// next-cycle implication
`define MDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mde next-cycle check failed");

`endif

@@ src/mde_pkg.sv @@
// ----------------------------------------------------------------------------
// mde_pkg
// Types, constants and helpers shared by the mandelbox distance estimator.
// ----------------------------------------------------------------------------
package mde_pkg;

  localparam int MAX_ITER_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RADIUS_SQ      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RATIO        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_SCALE_LESS_ONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_POWER_OFFSET = 3'd4;

  typedef logic signed [47:0] vec_t;

  localparam vec_t ONE_Q16 = 48'sd65536;
  localparam logic signed [65:0] SAT_LIM = 66'sh7FFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_FOLD, OP_SQ, OP_ACC, OP_FSEL, OP_FTAKE, OP_DSTEP,
    OP_MHI, OP_MLO, OP_MEND, OP_ADD, OP_NLOAD, OP_NSHIFT, OP_RLOAD, OP_RSTEP,
    OP_QLOAD, OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    BSEL_F, BSEL_SCALE, BSEL_ABS
  } bsel_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
    logic       use_tmp;
    logic       use_norm;
    bsel_t      bsel;
  } cmd_t;

  typedef struct packed {
    logic oversize;
    logic need_div;
    logic step_last;
    logic norm_ok;
    logic stop;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FOLD, S_SQ, S_SQACC, S_FSEL, S_FDIV, S_FTAKE, S_MHI, S_MLO,
    S_MEND, S_ADD, S_CHECK, S_NLD, S_NORM, S_FSQ, S_FSQACC, S_RLD, S_ROOT,
    S_QLD, S_QDIV, S_DONE
  } state_t;

  function automatic vec_t sat47(input logic signed [65:0] v);
    if (v > SAT_LIM) begin
      return SAT_LIM[47:0];
    end else if (v < -SAT_LIM) begin
      return vec_t'(-SAT_LIM);
    end else begin
      return v[47:0];
    end
  endfunction

endpackage

@@ src/mde_datapath.sv @@
// ----------------------------------------------------------------------------
// mde_datapath
// Fold vector, derivative weight, shared multiplier, serial divider and
// serial square root, driven one command per cycle.
// ----------------------------------------------------------------------------
`include "mandelbox_distance_estimate_macros.svh"

module mde_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_point_z,
  input  logic [16:0]         min_radius_sq,
  input  logic signed [31:0]  scale_ratio,
  input  logic [30:0]         abs_scale_less_one,
  input  logic [30:0]         scale_power_offset,
  input  mde_pkg::cmd_t       cmd,
  output mde_pkg::status_t    status,
  output logic                out_valid,
  output logic signed [31:0]  out_surface_distance
);
  import mde_pkg::*;

  vec_t px_r, py_r, pz_r, w_r, tmp_r;
  logic signed [31:0] p0x_r, p0y_r, p0z_r;
  logic signed [65:0] prod_r, hi_r;
  logic [63:0] sum_r;
  logic large_r;
  logic [16:0] f_r;
  logic [47:0] rem_r, d_r;
  logic [63:0] q_r;
  logic [5:0] cnt_r;
  logic [63:0] x_r, res_r, bit_r;
  logic [47:0] mx_r, my_r, mz_r;
  logic [4:0] k_r;
  logic neg_r;
  logic out_valid_r;
  logic signed [31:0] out_r;

  function automatic logic [47:0] mag48(input vec_t v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic vec_t fold1(input vec_t v);
    vec_t c;
    logic signed [65:0] t;
    if (v > ONE_Q16) c = ONE_Q16;
    else if (v < -ONE_Q16) c = -ONE_Q16;
    else c = v;
    t = ($signed({{18{c[47]}}, c}) <<< 1) - $signed({{18{v[47]}}, v});
    return sat47(t);
  endfunction

  vec_t tgt, opa, fx, fy, fz, addend, add_res;
  logic signed [31:0] p0_sel;
  logic [47:0] sq_mag, nm_sel;
  logic signed [32:0] a_m, b_m, abs_s, sc33;
  logic signed [65:0] prod;
  logic f_le;
  logic [48:0] dsh;
  logic [63:0] rb;
  logic [48:0] len;
  logic signed [49:0] num;
  logic [47:0] qmag;
  logic signed [65:0] qs, fin;
  logic signed [31:0] fin_sat;

  always_comb begin
    unique case (cmd.sel)
      2'd0: begin tgt = px_r; p0_sel = p0x_r; nm_sel = mx_r; end
      2'd1: begin tgt = py_r; p0_sel = p0y_r; nm_sel = my_r; end
      2'd2: begin tgt = pz_r; p0_sel = p0z_r; nm_sel = mz_r; end
      default: begin tgt = w_r; p0_sel = p0x_r; nm_sel = mx_r; end
    endcase
    opa = cmd.use_tmp ? tmp_r : tgt;
    sq_mag = cmd.use_norm ? nm_sel : mag48(tgt);
    sc33 = {scale_ratio[31], scale_ratio};
    abs_s = scale_ratio[31] ? -sc33 : sc33;
    case (cmd.bsel)
      BSEL_SCALE: b_m = sc33;
      BSEL_ABS:   b_m = abs_s;
      default:    b_m = $signed({16'b0, f_r});
    endcase
    case (cmd.op)
      OP_MHI: a_m = $signed({opa[47], opa[47:16]});
      OP_MLO: a_m = $signed({17'b0, opa[15:0]});
      default: begin
        a_m = $signed({1'b0, sq_mag[31:0]});
        if (cmd.op == OP_SQ) b_m = $signed({1'b0, sq_mag[31:0]});
      end
    endcase
    prod = a_m * b_m;

    fx = fold1(px_r);
    fy = fold1(py_r);
    fz = fold1(pz_r);

    addend = (cmd.sel == 2'd3) ? ONE_Q16 : vec_t'(p0_sel);
    add_res = sat47($signed({{18{tmp_r[47]}}, tmp_r}) + $signed({{18{addend[47]}}, addend}));

    f_le = !large_r && (sum_r <= {31'b0, min_radius_sq, 16'b0});
    dsh = {rem_r, q_r[63]};
    rb = res_r + bit_r;

    len = 49'(res_r[32:0]) << k_r;
    num = $signed({1'b0, len}) - $signed({19'b0, abs_scale_less_one});
    qmag = num[49] ? 48'(-num) : 48'(num);

    qs = $signed({2'b0, q_r});
    fin = (neg_r ? -qs : qs) - $signed({35'b0, scale_power_offset});
    if (fin > 66'sd2147483647) fin_sat = 32'sh7FFF_FFFF;
    else if (fin < -66'sd2147483648) fin_sat = 32'sh8000_0000;
    else fin_sat = fin[31:0];

    status.oversize = large_r;
    status.need_div = !large_r && !f_le && (sum_r[63:32] == 32'b0);
    status.step_last = (cnt_r == 6'd0);
    status.norm_ok = (mx_r[47:31] == 17'b0) && (my_r[47:31] == 17'b0)
                     && (mz_r[47:31] == 17'b0);
    status.stop = large_r || (sum_r > (64'd1000 << 32));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px_r <= vec_t'(in_point_x);
        py_r <= vec_t'(in_point_y);
        pz_r <= vec_t'(in_point_z);
        p0x_r <= in_point_x;
        p0y_r <= in_point_y;
        p0z_r <= in_point_z;
        w_r <= ONE_Q16;
      end
      OP_FOLD: begin
        px_r <= fx;
        py_r <= fy;
        pz_r <= fz;
        large_r <= (mag48(fx) >= 48'd67108864) || (mag48(fy) >= 48'd67108864)
                   || (mag48(fz) >= 48'd67108864);
        sum_r <= 64'b0;
      end
      OP_SQ, OP_MHI: prod_r <= prod;
      OP_MLO: begin
        hi_r <= prod_r;
        prod_r <= prod;
      end
      OP_MEND: tmp_r <= sat47(hi_r + (prod_r >>> 16));
      OP_ACC: sum_r <= sum_r + prod_r[63:0];
      OP_ADD: begin
        case (cmd.sel)
          2'd0: px_r <= add_res;
          2'd1: py_r <= add_res;
          2'd2: pz_r <= add_res;
          default: w_r <= add_res;
        endcase
      end
      OP_FSEL: begin
        if (f_le) begin
          f_r <= 17'd65536;
        end else if (status.need_div) begin
          rem_r <= {16'b0, min_radius_sq, 15'b0};
          q_r <= 64'b0;
          d_r <= {16'b0, sum_r[31:0]};
          cnt_r <= 6'd16;
        end else begin
          f_r <= (min_radius_sq > 17'd65536) ? 17'd65536 : min_radius_sq;
        end
      end
      OP_FTAKE: f_r <= q_r[16:0];
      OP_DSTEP: begin
        if (dsh >= {1'b0, d_r}) begin
          rem_r <= 48'(dsh - {1'b0, d_r});
          q_r <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= dsh[47:0];
          q_r <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
      end
      OP_NLOAD: begin
        mx_r <= mag48(px_r);
        my_r <= mag48(py_r);
        mz_r <= mag48(pz_r);
        k_r <= 5'd0;
        sum_r <= 64'b0;
      end
      OP_NSHIFT: begin
        mx_r <= mx_r >> 1;
        my_r <= my_r >> 1;
        mz_r <= mz_r >> 1;
        k_r <= k_r + 5'd1;
      end
      OP_RLOAD: begin
        x_r <= sum_r;
        res_r <= 64'b0;
        bit_r <= 64'd1 << 62;
        cnt_r <= 6'd31;
      end
      OP_RSTEP: begin
        if (x_r >= rb) begin
          x_r <= x_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 6'd1;
      end
      OP_QLOAD: begin
        neg_r <= num[49];
        rem_r <= 48'b0;
        q_r <= {qmag, 16'b0};
        d_r <= w_r[47:0];
        cnt_r <= 6'd63;
      end
      OP_FINISH: out_r <= fin_sat;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_surface_distance = out_r;

  `MDE_ASSERT_NEXT(a_out_after_finish, clk, rst_n, cmd.op == OP_FINISH, out_valid_r)
  `MDE_ASSERT_SAME(a_div_rem_bound, clk, rst_n, cmd.op == OP_DSTEP, rem_r < d_r)
  `MDE_ASSERT_SAME(a_fold_quot_width, clk, rst_n, cmd.op == OP_FTAKE, q_r[63:17] == 47'b0)
endmodule

@@ src/mde_ctrl.sv @@
// ----------------------------------------------------------------------------
// mde_ctrl
// Sequencer for the fold iterations and the final length and division.
// ----------------------------------------------------------------------------
`include "mandelbox_distance_estimate_macros.svh"

module mde_ctrl #(
  parameter int MAX_ITER = mde_pkg::MAX_ITER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [5:0]       iteration_count,
  input  mde_pkg::status_t status,
  output mde_pkg::cmd_t    cmd
);
  import mde_pkg::*;

  localparam int IW = $clog2(MAX_ITER + 1);

  state_t state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  logic pass_r, pass_nxt;
  logic [IW-1:0] it_r, it_nxt, n_r, n_nxt;
  logic [6:0] n_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r <= 2'd0;
      pass_r <= 1'b0;
      it_r <= '0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      j_r <= j_nxt;
      pass_r <= pass_nxt;
      it_r <= it_nxt;
      n_r <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r;
    pass_nxt = pass_r;
    it_nxt = it_r;
    n_nxt = n_r;
    busy = 1'b1;
    cmd.op = OP_NOP;
    cmd.sel = j_r;
    cmd.use_tmp = pass_r;
    cmd.use_norm = 1'b0;
    cmd.bsel = pass_r ? ((j_r == 2'd3) ? BSEL_ABS : BSEL_SCALE) : BSEL_F;
    n_sel = (7'(iteration_count) > 7'(MAX_ITER)) ? 7'(MAX_ITER) : 7'(iteration_count);
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op = OP_LOAD;
          n_nxt = IW'(n_sel);
          it_nxt = '0;
          state_nxt = (n_sel == 7'd0) ? S_NLD : S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.op = OP_FOLD;
        j_nxt = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (status.oversize) begin
          state_nxt = S_FSEL;
        end else begin
          cmd.op = OP_SQ;
          state_nxt = S_SQACC;
        end
      end
      S_SQACC: begin
        cmd.op = OP_ACC;
        if (j_r == 2'd2) begin
          state_nxt = S_FSEL;
        end else begin
          j_nxt = j_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_FSEL: begin
        cmd.op = OP_FSEL;
        j_nxt = 2'd0;
        pass_nxt = 1'b0;
        state_nxt = status.need_div ? S_FDIV : S_MHI;
      end
      S_FDIV: begin
        cmd.op = OP_DSTEP;
        if (status.step_last) state_nxt = S_FTAKE;
      end
      S_FTAKE: begin
        cmd.op = OP_FTAKE;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.op = OP_MHI;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        cmd.op = OP_MLO;
        state_nxt = S_MEND;
      end
      S_MEND: begin
        cmd.op = OP_MEND;
        if (pass_r) begin
          state_nxt = S_ADD;
        end else begin
          pass_nxt = 1'b1;
          state_nxt = S_MHI;
        end
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        pass_nxt = 1'b0;
        if (j_r == 2'd3) begin
          state_nxt = S_CHECK;
        end else begin
          j_nxt = j_r + 2'd1;
          state_nxt = S_MHI;
        end
      end
      S_CHECK: begin
        it_nxt = it_r + 1'b1;
        if (status.stop || (IW'(it_r + 1'b1) == n_r)) state_nxt = S_NLD;
        else state_nxt = S_FOLD;
      end
      S_NLD: begin
        cmd.op = OP_NLOAD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        j_nxt = 2'd0;
        if (status.norm_ok) state_nxt = S_FSQ;
        else cmd.op = OP_NSHIFT;
      end
      S_FSQ: begin
        cmd.op = OP_SQ;
        cmd.use_norm = 1'b1;
        state_nxt = S_FSQACC;
      end
      S_FSQACC: begin
        cmd.op = OP_ACC;
        if (j_r == 2'd2) begin
          state_nxt = S_RLD;
        end else begin
          j_nxt = j_r + 2'd1;
          state_nxt = S_FSQ;
        end
      end
      S_RLD: begin
        cmd.op = OP_RLOAD;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.op = OP_RSTEP;
        if (status.step_last) state_nxt = S_QLD;
      end
      S_QLD: begin
        cmd.op = OP_QLOAD;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.op = OP_DSTEP;
        if (status.step_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.op = OP_FINISH;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `MDE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `MDE_ASSERT_SAME(a_iter_bound, clk, rst_n, state_r == S_CHECK, it_r < n_r)
  `MDE_ASSERT_SAME(a_sq_lane, clk, rst_n, state_r == S_SQ || state_r == S_FSQ, j_r != 2'd3)
endmodule

@@ src/mandelbox_distance_estimate.sv @@
// each fold iteration: a 17-step divider for the sphere fold when needed and eight multiplies
// on the shared multiplier; then the final length (normalize, 32-step root) and a 64-step division
// throughput: one item at a time, the next start is taken the cycle busy falls
// the result strobe lasts one cycle and cannot be held off
// reset: synchronous active-low rst_n; configuration, sequencer and out_valid registers return to defaults
// ----------------------------------------------------------------------------
// mandelbox_distance_estimate
// Mandelbox distance estimator: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module mandelbox_distance_estimate #(
  parameter int MAX_ITER = mde_pkg::MAX_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mde_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_point_x,
  input  logic signed [31:0]              in_point_y,
  input  logic signed [31:0]              in_point_z,
  output logic                            out_valid,
  output logic signed [31:0]              out_surface_distance
);
  import mde_pkg::*;

  logic [5:0] iteration_count_r;
  logic [16:0] min_radius_sq_r;
  logic signed [31:0] scale_ratio_r;
  logic [30:0] abs_scale_less_one_r;
  logic [30:0] scale_power_offset_r;

  cmd_t cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iteration_count_r <= 6'd15;
      min_radius_sq_r <= 17'd16384;
      scale_ratio_r <= 32'sd524288;
      abs_scale_less_one_r <= 31'd65536;
      scale_power_offset_r <= 31'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ITERATION_COUNT:    iteration_count_r <= cfg_wdata[5:0];
        CFG_MIN_RADIUS_SQ:      min_radius_sq_r <= cfg_wdata[16:0];
        CFG_SCALE_RATIO:        scale_ratio_r <= $signed(cfg_wdata);
        CFG_ABS_SCALE_LESS_ONE: abs_scale_less_one_r <= cfg_wdata[30:0];
        CFG_SCALE_POWER_OFFSET: scale_power_offset_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  mde_ctrl #(
    .MAX_ITER(MAX_ITER)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .iteration_count(iteration_count_r),
    .status(status),
    .cmd(cmd)
  );

  mde_datapath u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .min_radius_sq(min_radius_sq_r),
    .scale_ratio(scale_ratio_r),
    .abs_scale_less_one(abs_scale_less_one_r),
    .scale_power_offset(scale_power_offset_r),
    .cmd(cmd),
    .status(status),
    .out_valid(out_valid),
    .out_surface_distance(out_surface_distance)
  );
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives sample points into the mandelbox distance estimator under a series of
// register settings and checks every distance against a tabulated value or an in-bench
// fixed-point model of the fold loop, the final length and the division.
// ----------------------------------------------------------------------------
module tb_top;
  import mde_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam logic signed [63:0] SAT47 = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_ONE = 64'sd65536;
  localparam int MAX_FOLDS = 32;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    logic signed [31:0] want_dist;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_valid;
  logic signed [31:0] out_surface_distance;

  // model copy of the registers
  logic [5:0]         m_iters = 6'd15;
  logic [16:0]        m_min_r2 = 17'd16384;
  logic signed [31:0] m_scale = 32'sd524288;
  logic [30:0]        m_abs_less_one = 31'd65536;
  logic [30:0]        m_pow_offset = 31'd4;

  logic signed [31:0] distance_q[$];
  int errors = 0;
  int idle_cycles = 0;

  mandelbox_distance_estimate dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_surface_distance(out_surface_distance)
  );

  always #5 clk = ~clk;

  function automatic logic signed [63:0] clamp47(input logic signed [127:0] v);
    if (v > 128'(SAT47)) begin
      return SAT47;
    end else if (v < -128'(SAT47)) begin
      return -SAT47;
    end
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] prod;
    prod = 128'(a) * 128'(b);
    return clamp47(prod >>> 16);
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv, x;
    root = 0;
    x = v;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] predict_distance(input logic signed [31:0] x,
                                                          input logic signed [31:0] y,
                                                          input logic signed [31:0] z);
    logic signed [63:0] start_pt[3], p[3], w, c, f, abs_s, num, res;
    logic [63:0] r2, mr2, s, len, qi, rem, qmag, t, mg[3];
    int n, k;
    bit is_big;
    start_pt[0] = x;
    start_pt[1] = y;
    start_pt[2] = z;
    for (int j = 0; j < 3; j++) p[j] = start_pt[j];
    w = Q_ONE;
    abs_s = m_scale < 0 ? -64'(m_scale) : 64'(m_scale);
    n = m_iters > MAX_FOLDS ? MAX_FOLDS : int'(m_iters);
    mr2 = 64'(m_min_r2);
    for (int it = 0; it < n; it++) begin
      is_big = 0;
      r2 = 0;
      for (int j = 0; j < 3; j++) begin
        c = p[j];
        if (c > Q_ONE) c = Q_ONE;
        if (c < -Q_ONE) c = -Q_ONE;
        p[j] = clamp47(128'(c * 2 - p[j]));
        if (magnitude(p[j]) >= (64'd1 << 26)) is_big = 1;
      end
      if (!is_big) begin
        for (int j = 0; j < 3; j++) r2 = r2 + magnitude(p[j]) * magnitude(p[j]);
      end
      if (!is_big && r2 <= (mr2 << 16)) begin
        f = Q_ONE;
      end else if (!is_big && r2 < (64'd1 << 32)) begin
        f = 64'((mr2 << 32) / r2);
      end else begin
        f = mr2 > 64'd65536 ? Q_ONE : 64'(mr2);
      end
      for (int j = 0; j < 3; j++) begin
        p[j] = qmul(p[j], f);
        p[j] = clamp47(128'(qmul(p[j], 64'(m_scale))) + 128'(start_pt[j]));
      end
      w = qmul(w, f);
      w = clamp47(128'(qmul(w, abs_s)) + 128'(Q_ONE));
      if (is_big || r2 > (64'd1000 << 32)) break;
    end
    for (int j = 0; j < 3; j++) mg[j] = magnitude(p[j]);
    k = 0;
    while ((mg[0] >> k) >= (64'd1 << 31) || (mg[1] >> k) >= (64'd1 << 31) ||
           (mg[2] >> k) >= (64'd1 << 31)) k++;
    s = 0;
    for (int j = 0; j < 3; j++) begin
      t = mg[j] >> k;
      s = s + t * t;
    end
    len = int_sqrt(s) << k;
    num = $signed(len) - 64'(m_abs_less_one);
    qmag = magnitude(num);
    qi = qmag / 64'(w);
    rem = qmag % 64'(w);
    qmag = qi * 64'd65536 + (rem * 64'd65536) / 64'(w);
    res = num < 0 ? -$signed(qmag) : $signed(qmag);
    res = res - 64'(m_pow_offset);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (distance_q.size() == 0) begin
        report_mismatch("unexpected item", out_surface_distance, 0);
      end else begin
        logic signed [31:0] want;
        want = distance_q.pop_front();
        if (out_surface_distance !== want) begin
          report_mismatch("surface_distance", out_surface_distance, want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (distance_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ITERATION_COUNT:    m_iters = data[5:0];
      CFG_MIN_RADIUS_SQ:      m_min_r2 = data[16:0];
      CFG_SCALE_RATIO:        m_scale = data;
      CFG_ABS_SCALE_LESS_ONE: m_abs_less_one = data[30:0];
      CFG_SCALE_POWER_OFFSET: m_pow_offset = data[30:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] iters, input logic [31:0] min_r2,
                            input logic [31:0] scale, input logic [31:0] less_one,
                            input logic [31:0] pow_off);
    wait_drained();
    write_reg(CFG_ITERATION_COUNT, iters);
    write_reg(CFG_MIN_RADIUS_SQ, min_r2);
    write_reg(CFG_SCALE_RATIO, scale);
    write_reg(CFG_ABS_SCALE_LESS_ONE, less_one);
    write_reg(CFG_SCALE_POWER_OFFSET, pow_off);
    // unused indexes must be ignored
    write_reg(3'd5 + 3'($urandom_range(0, 2)), $urandom());
    cfg_we <= 1'b0;
  endtask

  // keep_start leaves start high so the next item follows back to back
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input bit keep_start,
                            input bit typed, input logic signed [31:0] want_dist);
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (busy);
    distance_q = {distance_q, (typed ? want_dist : predict_distance(x, y, z))};
    if (!keep_start) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0005_0000)) - 32'sh0002_8000;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  point_row_t rows[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, -32'sd65540},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 32'sh7FFF_FFFF},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b1, 32'sh7FFF_FFFF},
    '{32'sd65536, 32'sd0, 32'sd0, 1'b0, 0},
    '{-32'sd65536, 32'sd65536, -32'sd65536, 1'b0, 0},
    '{32'sd32768, 32'sd0, 32'sd0, 1'b0, 0},
    '{32'sd16384, 32'sd16384, 32'sd0, 1'b0, 0},
    '{32'sd1, -32'sd1, 32'sd1, 1'b0, 0},
    '{32'sd131072, 32'sd98304, -32'sd65537, 1'b0, 0},
    '{32'sd65536000, 32'sd0, 32'sd0, 1'b0, 0},
    '{32'sd2072576, 32'sd2072576, 32'sd2072576, 1'b0, 0},
    '{-32'sd40000, 32'sd50000, 32'sd20000, 1'b0, 0},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b0, 0}
  };

  initial begin
    int mode, gap, burst;
    logic signed [31:0] sr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, model only
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, 1'b0, 0);

    // zero iterations: distance read straight from the point
    set_config(0, 16384, 524288, 65536, 4);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z,
                                 i < rows.size() - 1, rows[i].typed, rows[i].want_dist);

    // register extremes and special settings
    set_config(63, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, 1'b0, 0);
    set_config(32, 131071, 32'h7FFF_FFFF, 0, 0);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, 1'b0, 0);
    set_config(1, 65536, 32'hFFFF_0000, 131072, 1);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, 1'b0, 1'b0, 0);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 3 == 2) begin
        sr = $urandom();
      end else begin
        sr = $signed($urandom_range(65536, 196608)) * 4;
        if ($urandom_range(0, 1)) sr = -sr;
      end
      set_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 16),
                 $urandom_range(0, 4) == 0 ? $urandom_range(0, 131071)
                                           : $urandom_range(4096, 65536),
                 sr, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 262144),
                 $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1024));
      burst = 0;
      for (int i = 0; i < 125; i++) begin
        mode = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2);
        if (burst > 0) begin
          gap = 0;
          burst--;
        end else if ($urandom_range(0, 9) == 0) begin
          burst = $urandom_range(5, 20);
          gap = 0;
        end else begin
          gap = $urandom_range(0, 17);
        end
        if ($urandom_range(0, 49) == 0) wait_drained();
        send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), gap == 0,
                   1'b0, 0);
        repeat (gap) @(posedge clk);
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
